[rtl/e2q_pkg.sv]
// Package for the Euler-angle to quaternion converter.
// Holds CORDIC constants and the arctangent table; no dependencies.
package e2q_pkg;

  localparam int unsigned CordicStages = 30;
  localparam int unsigned StageIdxBits = 5;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Datapath widths for the CORDIC cells (Q30 plus headroom).
  localparam int unsigned XyBits = 34;
  localparam int unsigned ZBits  = 34;

  typedef logic signed [XyBits-1:0] xy_t;
  typedef logic signed [ZBits-1:0]  z_t;

  // Sine and cosine of the three half angles.
  typedef struct packed {
    xy_t cp;
    xy_t sp;
    xy_t cy;
    xy_t sy;
    xy_t cr;
    xy_t sr;
  } trig_t;

  function automatic z_t atan_val(input logic [StageIdxBits-1:0] idx);
    z_t v;
    case (idx)
      5'd0:  v = 34'sd1073741824;
      5'd1:  v = 34'sd633866812;
      5'd2:  v = 34'sd334917814;
      5'd3:  v = 34'sd170009512;
      5'd4:  v = 34'sd85334662;
      5'd5:  v = 34'sd42708930;
      5'd6:  v = 34'sd21359676;
      5'd7:  v = 34'sd10680490;
      5'd8:  v = 34'sd5340326;
      5'd9:  v = 34'sd2670174;
      5'd10: v = 34'sd1335088;
      5'd11: v = 34'sd667544;
      5'd12: v = 34'sd333772;
      5'd13: v = 34'sd166886;
      5'd14: v = 34'sd83444;
      5'd15: v = 34'sd41722;
      5'd16: v = 34'sd20860;
      5'd17: v = 34'sd10430;
      5'd18: v = 34'sd5216;
      5'd19: v = 34'sd2608;
      5'd20: v = 34'sd1304;
      5'd21: v = 34'sd652;
      5'd22: v = 34'sd326;
      5'd23: v = 34'sd162;
      5'd24: v = 34'sd82;
      5'd25: v = 34'sd40;
      5'd26: v = 34'sd20;
      5'd27: v = 34'sd10;
      5'd28: v = 34'sd6;
      5'd29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/e2q_cordic_cell.sv]
// One CORDIC rotation cell for three angles in parallel, registered output.
// Uses e2q_pkg for widths and the arctangent table.
module e2q_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  e2q_pkg::xy_t [2:0]      x_i,
  input  e2q_pkg::xy_t [2:0]      y_i,
  input  e2q_pkg::z_t  [2:0]      z_i,
  output logic                    vld_o,
  output e2q_pkg::xy_t [2:0]      x_o,
  output e2q_pkg::xy_t [2:0]      y_o,
  output e2q_pkg::z_t  [2:0]      z_o
);

  localparam e2q_pkg::z_t Atan =
    e2q_pkg::atan_val(Stage[e2q_pkg::StageIdxBits-1:0]);

  logic             vld_q;
  e2q_pkg::xy_t [2:0] x_d, x_q, y_d, y_q;
  e2q_pkg::z_t  [2:0] z_d, z_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][e2q_pkg::ZBits-1]) begin
        x_d[k] = x_i[k] - (y_i[k] >>> Stage);
        y_d[k] = y_i[k] + (x_i[k] >>> Stage);
        z_d[k] = z_i[k] - Atan;
      end else begin
        x_d[k] = x_i[k] + (y_i[k] >>> Stage);
        y_d[k] = y_i[k] - (x_i[k] >>> Stage);
        z_d[k] = z_i[k] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign vld_o = vld_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

[rtl/e2q_combine.sv]
// Forms the four quaternion components from half-angle sines and cosines.
// Three register stages: pair product, triple product, sum and saturation.
// Uses e2q_pkg for trig_t.
module e2q_combine #(
  parameter int unsigned CompBits = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  e2q_pkg::trig_t             trig_i,
  output logic                       vld_o,
  output logic signed [CompBits-1:0] scalar_o,
  output logic signed [CompBits-1:0] lambda_o,
  output logic signed [CompBits-1:0] mu_o,
  output logic signed [CompBits-1:0] nu_o
);

  localparam int unsigned Frac  = CompBits - 2;
  localparam int unsigned Shift = 60 - Frac;
  localparam int unsigned PBits = 64;

  typedef logic signed [PBits-1:0] p_t;
  localparam p_t RndQ30 = p_t'(64'sd1 <<< 29);
  localparam p_t RndOut = p_t'(64'sd1 <<< (Shift - 1));
  localparam p_t One    = p_t'(64'sd1 <<< Frac);

  // Pairs: 0 cy*cp, 1 sy*sp, 2 sy*cp, 3 cy*sp; third factors cr / sr.
  logic [2:0]            vld_q;
  p_t   [3:0]            pair_q;
  e2q_pkg::xy_t          cr_q, sr_q;
  p_t   [7:0]            term_q;
  logic signed [CompBits-1:0] res_q [4];
  p_t   [3:0]            pr_d;
  p_t   [7:0]            term_d;
  p_t   [3:0]            sum;
  logic signed [CompBits-1:0] res_d [4];

  always_comb begin
    pr_d[0] = (p_t'(trig_i.cy) * p_t'(trig_i.cp) + RndQ30) >>> 30;
    pr_d[1] = (p_t'(trig_i.sy) * p_t'(trig_i.sp) + RndQ30) >>> 30;
    pr_d[2] = (p_t'(trig_i.sy) * p_t'(trig_i.cp) + RndQ30) >>> 30;
    pr_d[3] = (p_t'(trig_i.cy) * p_t'(trig_i.sp) + RndQ30) >>> 30;
    for (int k = 0; k < 4; k++) begin
      term_d[2*k]   = pair_q[k] * p_t'(cr_q);
      term_d[2*k+1] = pair_q[k] * p_t'(sr_q);
    end
    sum[0] = term_q[0] - term_q[3];
    sum[1] = term_q[2] + term_q[1];
    sum[2] = term_q[4] + term_q[7];
    sum[3] = term_q[6] - term_q[5];
    for (int k = 0; k < 4; k++) begin
      p_t r;
      r = (sum[k] + RndOut) >>> Shift;
      if (r > One) r = One;
      if (r < -One) r = -One;
      res_d[k] = r[CompBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pr_d;
    cr_q   <= trig_i.cr;
    sr_q   <= trig_i.sr;
    term_q <= term_d;
    for (int k = 0; k < 4; k++) begin
      res_q[k] <= res_d[k];
    end
  end

  assign vld_o    = vld_q[2];
  assign scalar_o = res_q[0];
  assign lambda_o = res_q[1];
  assign mu_o     = res_q[2];
  assign nu_o     = res_q[3];

endmodule

[rtl/euler_to_quaternion_top.sv]
// Euler angles to quaternion converter, top level.
// Instantiates e2q_cordic_cell (chain) and e2q_combine; uses e2q_pkg.
//
// Usage: drive pitch/yaw/roll angles (signed binary angles, 2^ANGLE_BITS per
// turn) and pulse start. busy is always low, so a request is taken on
// every cycle start is high; one request per cycle is sustained.
// The half angles pass through a chain of 30 CORDIC cells, one register each,
// then three stages of products and rounding: 33 registers in all. done_o is
// high once the request has left the last of these registers, and the four
// components (signed Q1.(COMPONENT_BITS-2), saturated to +/-1.0) are then on
// the q_* ports.
// Results show for one cycle only; the receiver cannot stall the block.
// Reset clears all valid flags; data registers are not reset. No state is
// kept between requests.
module euler_to_quaternion_top #(
  parameter int unsigned ANGLE_BITS     = 24,
  parameter int unsigned COMPONENT_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [ANGLE_BITS-1:0]     pitch_angle_i,
  input  logic signed [ANGLE_BITS-1:0]     yaw_angle_i,
  input  logic signed [ANGLE_BITS-1:0]     roll_angle_i,
  output logic                             done_o,
  output logic signed [COMPONENT_BITS-1:0] q_scalar_o,
  output logic signed [COMPONENT_BITS-1:0] q_lambda_o,
  output logic signed [COMPONENT_BITS-1:0] q_mu_o,
  output logic signed [COMPONENT_BITS-1:0] q_nu_o
);

  localparam int unsigned N = e2q_pkg::CordicStages;

  logic                vld   [N+1];
  e2q_pkg::xy_t [2:0]  xs    [N+1];
  e2q_pkg::xy_t [2:0]  ys    [N+1];
  e2q_pkg::z_t  [2:0]  zs    [N+1];
  e2q_pkg::trig_t      trig;

  assign busy   = 1'b0;
  assign vld[0] = start;

  // Half angle: scale to 2^33 per turn (phase in Q32 of half turns).
  assign xs[0] = {3{e2q_pkg::CordicGain}};
  assign ys[0] = '0;
  assign zs[0] = {e2q_pkg::z_t'(roll_angle_i)  <<< (32 - ANGLE_BITS),
                  e2q_pkg::z_t'(yaw_angle_i)   <<< (32 - ANGLE_BITS),
                  e2q_pkg::z_t'(pitch_angle_i) <<< (32 - ANGLE_BITS)};

  for (genvar g = 0; g < N; g++) begin : g_cell
    e2q_cordic_cell #(.Stage(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .x_i    (xs[g]),
      .y_i    (ys[g]),
      .z_i    (zs[g]),
      .vld_o  (vld[g+1]),
      .x_o    (xs[g+1]),
      .y_o    (ys[g+1]),
      .z_o    (zs[g+1])
    );
  end

  assign trig.cp = xs[N][0];
  assign trig.sp = ys[N][0];
  assign trig.cy = xs[N][1];
  assign trig.sy = ys[N][1];
  assign trig.cr = xs[N][2];
  assign trig.sr = ys[N][2];

  e2q_combine #(.CompBits(COMPONENT_BITS)) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld[N]),
    .trig_i   (trig),
    .vld_o    (done_o),
    .scalar_o (q_scalar_o),
    .lambda_o (q_lambda_o),
    .mu_o     (q_mu_o),
    .nu_o     (q_nu_o)
  );

endmodule

[rtl/e2q_checker.sv]
// Port-level checks for the quaternion converter, bound to the top level.
// Depends on euler_to_quaternion_top port names only.
module e2q_checker #(
  parameter int unsigned COMPONENT_BITS = 24
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic signed [COMPONENT_BITS-1:0] q_scalar_o,
  input logic signed [COMPONENT_BITS-1:0] q_lambda_o
);

  localparam logic signed [COMPONENT_BITS-1:0] One = {2'b01, {(COMPONENT_BITS-2){1'b0}}};

  // Each accepted request must raise done_o once it has passed the whole pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##33 done_o)
    else $error("result missing after request");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_sat_s: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (q_scalar_o <= One && q_scalar_o >= -One))
    else $error("scalar out of range");

  a_sat_l: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (q_lambda_o <= One && q_lambda_o >= -One))
    else $error("lambda out of range");

endmodule

bind euler_to_quaternion_top e2q_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_e2q_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .q_scalar_o (q_scalar_o),
  .q_lambda_o (q_lambda_o)
);

[test/tb_euler_to_quaternion_top.sv]
// Testbench for euler_to_quaternion_top: drives angle requests, predicts the
// quaternion with a bit-exact CORDIC/product model and checks each done_o.
// Depends on rtl/euler_to_quaternion_top.sv and rtl/e2q_pkg.sv.
module tb_euler_to_quaternion_top;

  localparam int unsigned AngleBits = 24;
  localparam int unsigned CompBits  = 24;
  localparam int unsigned FracBits  = CompBits - 2;
  localparam int unsigned Stages    = 30;
  localparam longint      GainQ30   = 652032874;
  localparam int unsigned Latency   = 33;
  localparam longint      CycleLimit = 400000;

  typedef struct packed {
    logic signed [CompBits-1:0] scalar;
    logic signed [CompBits-1:0] lambda;
    logic signed [CompBits-1:0] mu;
    logic signed [CompBits-1:0] nu;
  } quat_t;

  logic clk_i, rst_ni, start, busy, done_o;
  logic signed [AngleBits-1:0] pitch_angle_i, yaw_angle_i, roll_angle_i;
  logic signed [CompBits-1:0]  q_scalar_o, q_lambda_o, q_mu_o, q_nu_o;

  quat_t  quat_q[$];
  int     n_errors;
  longint n_cycles;
  bit     gaps_on;

  longint atan_lut [Stages] = '{
    1073741824, 633866812, 334917814, 170009512, 85334662, 42708930,
    21359676, 10680490, 5340326, 2670174, 1335088, 667544, 333772,
    166886, 83444, 41722, 20860, 10430, 5216, 2608, 1304, 652, 326,
    162, 82, 40, 20, 10, 6, 2
  };

  euler_to_quaternion_top #(
    .ANGLE_BITS    (AngleBits),
    .COMPONENT_BITS(CompBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pitch_angle_i(pitch_angle_i),
    .yaw_angle_i  (yaw_angle_i),
    .roll_angle_i (roll_angle_i),
    .done_o       (done_o),
    .q_scalar_o   (q_scalar_o),
    .q_lambda_o   (q_lambda_o),
    .q_mu_o       (q_mu_o),
    .q_nu_o       (q_nu_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // half angle to cos/sin in Q30 (>>> on longint is a floor shift)
  task automatic half_angle_trig(input logic signed [AngleBits-1:0] ang,
                                 output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GainQ30;
    y = 0;
    z = longint'(ang) <<< (32 - AngleBits);
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = x;
    s = y;
  endtask

  function automatic longint triple_q60(longint a, longint b, longint c);
    longint ab;
    ab = (a * b + (longint'(1) <<< 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [CompBits-1:0] round_sat(longint q60);
    longint one, r;
    one = longint'(1) <<< FracBits;
    r = (q60 + (longint'(1) <<< (59 - FracBits))) >>> (60 - FracBits);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[CompBits-1:0];
  endfunction

  task automatic predict_quat(input logic signed [AngleBits-1:0] p, y, r,
                              output quat_t q);
    longint cp, sp, cy, sy, cr, sr;
    half_angle_trig(p, cp, sp);
    half_angle_trig(y, cy, sy);
    half_angle_trig(r, cr, sr);
    q.scalar = round_sat(triple_q60(cy, cp, cr) - triple_q60(sy, sp, sr));
    q.lambda = round_sat(triple_q60(sy, sp, cr) + triple_q60(cy, cp, sr));
    q.mu     = round_sat(triple_q60(sy, cp, cr) + triple_q60(cy, sp, sr));
    q.nu     = round_sat(triple_q60(cy, sp, cr) - triple_q60(sy, cp, sr));
  endtask

  task automatic report_mismatch(input string what, input logic [CompBits-1:0] got,
                                 input logic [CompBits-1:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && done_o) begin
      if (quat_q.size() == 0) begin
        report_mismatch("unexpected result", q_scalar_o, '0);
      end else begin
        want = quat_q.pop_front();
        if (q_scalar_o !== want.scalar) report_mismatch("scalar", q_scalar_o, want.scalar);
        if (q_lambda_o !== want.lambda) report_mismatch("lambda", q_lambda_o, want.lambda);
        if (q_mu_o !== want.mu) report_mismatch("mu", q_mu_o, want.mu);
        if (q_nu_o !== want.nu) report_mismatch("nu", q_nu_o, want.nu);
      end
    end
  end

  // one request; start stays high into the next call unless a gap is taken
  task automatic send_angles(input logic [AngleBits-1:0] p, y, r);
    quat_t q;
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    pitch_angle_i <= p;
    yaw_angle_i   <= y;
    roll_angle_i  <= r;
    do @(posedge clk_i); while (busy);
    predict_quat(p, y, r, q);
    quat_q.push_back(q);
    @(negedge clk_i);
  endtask

  function automatic logic [AngleBits-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return {2'($urandom_range(0, 3)), {(AngleBits-2){1'b0}}}; // quarter turns
      1: return AngleBits'({3'($urandom_range(0, 7)), {(AngleBits-3){1'b0}}}
                           + $urandom_range(0, 3) - 2);
      default: return AngleBits'($urandom());
    endcase
  endfunction

  task automatic test_directed_extremes();
    logic [AngleBits-1:0] edges [6] = '{24'h000000, 24'h7FFFFF, 24'h800000,
                                        24'hFFFFFF, 24'h400000, 24'hC00000};
    for (int i = 0; i < 6; i++) send_angles(edges[i], edges[i], edges[i]);
    for (int i = 0; i < 6; i++) send_angles(edges[i], 24'h000000, 24'h7FFFFF);
    for (int i = 0; i < 6; i++) send_angles(24'h800000, edges[i], 24'h400000);
    for (int i = 0; i < 6; i++) send_angles(24'hC00000, 24'hFFFFFF, edges[i]);
  endtask

  task automatic test_random_angles(input int count);
    for (int i = 0; i < count; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_angles(AngleBits'($urandom()), AngleBits'($urandom()), AngleBits'($urandom()));
    end
  endtask

  initial begin
    int waited;
    n_errors = 0;
    n_cycles = 0;
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    pitch_angle_i = '0;
    yaw_angle_i = '0;
    roll_angle_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_extremes();
    test_random_angles(1600);
    test_back_to_back(300);
    start <= 1'b0;

    waited = 0;
    while (quat_q.size() != 0 && waited < 100 * Latency) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 4) @(posedge clk_i);

    if (n_errors == 0 && quat_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
